FILE: src/spr_pkg.sv
// Shared types and constants for the sequenced packet reorder core.
// Item layouts for both channels, the queue entry, the slot entry and result kinds.
// No dependencies.
package spr_pkg;

    localparam int SPR_WINDOW     = 32;
    localparam int SPR_MAX_PACKET = 2047;
    localparam int SPR_QDEPTH     = 2;

    localparam logic [10:0] SPR_MIN_PACKET   = 11'd6;
    localparam logic [10:0] SPR_HEADER_BYTES = 11'd5;

    localparam logic [1:0] KIND_INORDER = 2'd0;
    localparam logic [1:0] KIND_ASYNC   = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;
    localparam logic [1:0] KIND_DROPPED = 2'd3;

    typedef struct packed {
        logic [10:0] packet_length;
        logic [31:0] seq_number;
        logic        is_final;
        logic [15:0] payload_handle;
    } pkt_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] out_handle;
        logic [10:0] payload_length;
        logic        message_end;
        logic [31:0] ack_seq;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        is_async;
        logic [31:0] seq;
        logic        is_final;
        logic [10:0] len;
        logic [15:0] handle;
    } cmd_t;

    typedef struct packed {
        logic        is_final;
        logic [10:0] len;
        logic [15:0] handle;
    } slot_t;

    localparam int SPR_SLOT_W = $bits(slot_t);

endpackage

FILE: src/sequenced_packet_reorder_core.sv
// Top level of the sequenced packet reorder core: front end, queue, back end.
// Depends on spr_pkg, spr_front, spr_queue, spr_back, spr_ram.
//
//   channel   valid      ready      payload
//   input     pkt_valid  pkt_ready  pkt (spr_pkg::pkt_t)
//   result    res_valid  res_ready  res (spr_pkg::res_t)
//
// In the back end, an in-order packet releases any stored successors one slot per step,
// walking the slot RAM (registered read) through the CHK and EMIT states.
// Reset clears the expected sequence to 1 and all slot valid bits at once; no sweep.
// Dropped short or oversize packets give no result.
// A two-entry queue keeps the input open while the back end waits on res_ready.
module sequenced_packet_reorder_core #(
    parameter int WINDOW = spr_pkg::SPR_WINDOW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pkt_valid,
    output logic          pkt_ready,
    input  spr_pkg::pkt_t pkt,
    output logic          res_valid,
    input  logic          res_ready,
    output spr_pkg::res_t res
);

    import spr_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_wdata;
    cmd_t q_rdata;

    spr_front u_front (
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    spr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    spr_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

FILE: src/spr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Parameters set word width and depth. No dependencies.
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/spr_front.sv
// Front end: accepts packet headers, drops short and oversize ones,
// marks async packets and strips the header length. Uses spr_pkg.
module spr_front (
    input  logic          pkt_valid,
    output logic          pkt_ready,
    input  spr_pkg::pkt_t pkt,
    input  logic          q_full,
    output logic          q_push,
    output spr_pkg::cmd_t q_wdata
);

    import spr_pkg::*;

    logic keep;

    assign keep = (pkt.packet_length >= SPR_MIN_PACKET)
               && ({21'd0, pkt.packet_length} <= 32'(SPR_MAX_PACKET));

    assign pkt_ready = !q_full;
    assign q_push    = pkt_valid && !q_full && keep;

    always_comb
    begin
        q_wdata.is_async = (pkt.seq_number == 32'd0);
        q_wdata.seq      = pkt.seq_number;
        q_wdata.is_final = pkt.is_final;
        q_wdata.len      = pkt.packet_length - SPR_HEADER_BYTES;
        q_wdata.handle   = pkt.payload_handle;
    end

endmodule

FILE: src/spr_queue.sv
// Short register queue between front and back ends.
// Holds classified packets so each side stalls on its own. Uses spr_pkg.
module spr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spr_pkg::cmd_t wdata,
    input  logic          pop,
    output spr_pkg::cmd_t rdata,
    output logic          full,
    output logic          empty
);

    import spr_pkg::*;

    localparam int PW = (SPR_QDEPTH > 1) ? $clog2(SPR_QDEPTH) : 1;
    localparam int CW = $clog2(SPR_QDEPTH + 1);

    cmd_t          entry_reg [SPR_QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(SPR_QDEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(SPR_QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(SPR_QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: src/spr_back.sv
// Back end: tracks the expected sequence, stores early packets in the slot RAM,
// drains stored successors and drives the result register. Uses spr_pkg, spr_ram.
module spr_back #(
    parameter int WINDOW = spr_pkg::SPR_WINDOW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  spr_pkg::cmd_t q_rdata,
    output logic          q_pop,
    output logic          res_valid,
    input  logic          res_ready,
    output spr_pkg::res_t res
);

    import spr_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam logic [2:0] ACT_ASYNC   = 3'd0;
    localparam logic [2:0] ACT_INORDER = 3'd1;
    localparam logic [2:0] ACT_FAR     = 3'd2;
    localparam logic [2:0] ACT_STORE   = 3'd3;
    localparam logic [2:0] ACT_ACK     = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [2:0]        act_reg, act_next;
    cmd_t              cur_reg, cur_next;
    logic [31:0]       exp_reg, exp_next;
    logic [IW-1:0]     exp_idx_reg, exp_idx_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [IW:0]       sum_reg, sum_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic              slot_free;
    logic [31:0]       diff;
    logic [31:0]       exp_inc;
    logic [IW-1:0]     idx_inc;
    logic [IW-1:0]     store_idx;
    logic [IW:0]       sum_wrap;
    logic              emit;
    res_t              emit_res;
    logic              wr_en;
    logic              rd_en;
    slot_t             wr_slot;
    slot_t             rd_slot;
    logic [SPR_SLOT_W-1:0] rd_word;

    assign slot_free = !out_valid_reg || res_ready;
    assign diff      = cur_reg.seq - exp_reg;
    assign exp_inc   = (exp_reg == '1) ? 32'd1 : exp_reg + 32'd1;
    assign idx_inc   = (exp_reg == '1) ? IW'(1)
                     : (exp_idx_reg == IW'(WINDOW - 1)) ? '0 : exp_idx_reg + 1'b1;
    assign sum_wrap  = sum_reg - (IW + 1)'(WINDOW);
    assign store_idx = (sum_reg >= (IW + 1)'(WINDOW)) ? sum_wrap[IW-1:0] : sum_reg[IW-1:0];
    assign rd_slot   = slot_t'(rd_word);

    always_comb
    begin
        wr_slot.is_final = cur_reg.is_final;
        wr_slot.len      = cur_reg.len;
        wr_slot.handle   = cur_reg.handle;
    end

    spr_ram #(
        .WIDTH (SPR_SLOT_W),
        .DEPTH (WINDOW),
        .AW    (IW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (store_idx),
        .wr_data (wr_slot),
        .rd_en   (rd_en),
        .rd_addr (exp_idx_reg),
        .rd_data (rd_word)
    );

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        cur_next     = cur_reg;
        exp_next     = exp_reg;
        exp_idx_next = exp_idx_reg;
        valid_next   = valid_reg;
        sum_next     = sum_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        emit         = 1'b0;
        emit_res     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_rdata;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                sum_next = {1'b0, exp_idx_reg} + {1'b0, diff[IW-1:0]};
                if (cur_reg.is_async)
                begin
                    act_next = ACT_ASYNC;
                end
                else if (cur_reg.seq == exp_reg)
                begin
                    act_next = ACT_INORDER;
                end
                else if (cur_reg.seq > exp_reg)
                begin
                    act_next = (diff >= 32'(WINDOW)) ? ACT_FAR : ACT_STORE;
                end
                else
                begin
                    act_next = ACT_ACK;
                end
                state_next = S_ACT;
            end
            S_ACT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    case (act_reg)
                        ACT_ASYNC:
                        begin
                            emit_res.result_kind    = KIND_ASYNC;
                            emit_res.out_handle     = cur_reg.handle;
                            emit_res.payload_length = cur_reg.len;
                            emit_res.message_end    = 1'b1;
                            emit_res.last           = 1'b1;
                        end
                        ACT_INORDER:
                        begin
                            emit_res.result_kind    = KIND_INORDER;
                            emit_res.out_handle     = cur_reg.handle;
                            emit_res.payload_length = cur_reg.len;
                            emit_res.message_end    = cur_reg.is_final;
                            exp_next                = exp_inc;
                            exp_idx_next            = idx_inc;
                            state_next              = S_CHK;
                        end
                        ACT_FAR:
                        begin
                            emit_res.result_kind = KIND_DROPPED;
                            emit_res.last        = 1'b1;
                        end
                        ACT_STORE:
                        begin
                            if (!valid_reg[store_idx])
                            begin
                                wr_en                 = 1'b1;
                                valid_next[store_idx] = 1'b1;
                            end
                            emit_res.result_kind = KIND_ACK;
                            emit_res.ack_seq     = cur_reg.seq;
                            emit_res.last        = 1'b1;
                        end
                        default:
                        begin
                            emit_res.result_kind = KIND_ACK;
                            emit_res.ack_seq     = cur_reg.seq;
                            emit_res.last        = 1'b1;
                        end
                    endcase
                end
            end
            S_CHK:
            begin
                if (valid_reg[exp_idx_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = S_EMIT;
                end
                else if (slot_free)
                begin
                    emit                 = 1'b1;
                    emit_res.result_kind = KIND_ACK;
                    emit_res.ack_seq     = cur_reg.seq;
                    emit_res.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    emit                    = 1'b1;
                    emit_res.result_kind    = KIND_INORDER;
                    emit_res.out_handle     = rd_slot.handle;
                    emit_res.payload_length = rd_slot.len;
                    emit_res.message_end    = rd_slot.is_final;
                    valid_next[exp_idx_reg] = 1'b0;
                    exp_next                = exp_inc;
                    exp_idx_next            = idx_inc;
                    state_next              = S_CHK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !res_ready);
        out_next       = emit ? emit_res : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_reg       <= 32'd1;
            exp_idx_reg   <= IW'(1);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            exp_idx_reg   <= exp_idx_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        cur_reg <= cur_next;
        sum_reg <= sum_next;
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
